FILE: src/iqd_pkg.sv
// ----------------------------------------------------------------------------
// iqd_pkg
// Shared types, codes and the register decode function of the input event queue device.
// ----------------------------------------------------------------------------
package iqd_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned EV_W           = 35;

  // item kinds on in_tuser
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_WRITE  = 3'd1;
  localparam logic [2:0] MODE_KEY    = 3'd2;
  localparam logic [2:0] MODE_TEXT   = 3'd3;
  localparam logic [2:0] MODE_MOVE   = 3'd4;
  localparam logic [2:0] MODE_BUTTON = 3'd5;
  localparam logic [2:0] MODE_SCROLL = 3'd6;

  // event type in bits [1:0] of an event word
  localparam logic [1:0] TYPE_KEY    = 2'd0;
  localparam logic [1:0] TYPE_TEXT   = 2'd1;
  localparam logic [1:0] TYPE_MOUSE  = 2'd2;
  localparam logic [1:0] TYPE_SCROLL = 2'd3;

  // mouse state codes
  localparam logic [1:0] MSTATE_MOVE = 2'd0;
  localparam logic [1:0] MSTATE_DOWN = 2'd1;
  localparam logic [1:0] MSTATE_UP   = 2'd2;

  // register offsets
  localparam logic [7:0] REG_STATUS    = 8'h00;
  localparam logic [7:0] REG_KEY_CODE  = 8'h04;
  localparam logic [7:0] REG_MODIFIERS = 8'h08;
  localparam logic [7:0] REG_STATE_A   = 8'h0C;
  localparam logic [7:0] REG_TEXT      = 8'h10;
  localparam logic [7:0] REG_ACK_A     = 8'h14;
  localparam logic [7:0] REG_PTR_X     = 8'h20;
  localparam logic [7:0] REG_PTR_Y     = 8'h24;
  localparam logic [7:0] REG_BUTTON    = 8'h28;
  localparam logic [7:0] REG_STATE_B   = 8'h2C;
  localparam logic [7:0] REG_SCROLL    = 8'h34;
  localparam logic [7:0] REG_ACK_B     = 8'h38;

  // status bits
  localparam logic [31:0] STAT_KEY    = 32'h1;
  localparam logic [31:0] STAT_MOUSE  = 32'h2;
  localparam logic [31:0] STAT_TEXT   = 32'h4;
  localparam logic [31:0] STAT_SCROLL = 32'h8;

  typedef logic [EV_W-1:0] event_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // register read decode on the held event
  function automatic logic [31:0] read_value(input event_t ev, input logic ev_valid,
                                             input logic [7:0] off,
                                             input logic [15:0] px, input logic [15:0] py);
    logic [31:0] v;
    logic [1:0]  ty;
    v  = '0;
    ty = ev[1:0];
    if (off == REG_PTR_X) begin
      v = {16'd0, px};
    end else if (off == REG_PTR_Y) begin
      v = {16'd0, py};
    end else if (ev_valid) begin
      case (off)
        REG_STATUS: begin
          case (ty)
            TYPE_KEY:   v = STAT_KEY;
            TYPE_MOUSE: v = STAT_MOUSE;
            TYPE_TEXT:  v = STAT_TEXT;
            default:    v = STAT_SCROLL;
          endcase
        end
        REG_KEY_CODE:  v = (ty == TYPE_KEY) ? {16'd0, ev[17:2]} : '0;
        REG_MODIFIERS: v = (ty == TYPE_KEY) ? {16'd0, ev[33:18]} : '0;
        REG_STATE_A, REG_STATE_B: begin
          if (ty == TYPE_KEY)        v = {31'd0, ev[34]};
          else if (ty == TYPE_MOUSE) v = {30'd0, ev[3:2]};
          else                       v = '0;
        end
        REG_TEXT:   v = (ty == TYPE_TEXT) ? {24'd0, ev[9:2]} : '0;
        REG_BUTTON: v = (ty == TYPE_MOUSE) ? {24'd0, ev[11:4]} : '0;
        REG_SCROLL: v = (ty == TYPE_SCROLL) ? {{16{ev[17]}}, ev[17:2]} : '0;
        default:    v = '0;
      endcase
    end
    return v;
  endfunction

endpackage

FILE: src/input_event_queue_device.sv
// ----------------------------------------------------------------------------
// input_event_queue_device
// Memory-mapped input device with an event ring and a register read port.
// ----------------------------------------------------------------------------
// Host events (key, text, mouse move, mouse button, scroll) and bus accesses
// arrive as items on the in_ stream, selected by in_tuser. Events are packed
// into a 35-bit word and pushed into a ring of RING_DEPTH entries that holds
// RING_DEPTH-1 events; when full, the event is dropped (move and button
// still load the pointer registers). A bus read pops one event into the held
// slot if none is held, then returns a register on out_tdata; a write to
// offset 0x14 or 0x38 drops the held event and pops the next. Writes produce
// no item; reads produce exactly one.
// An item that must pop the ring (read with nothing held and ring not empty,
// or acknowledge with ring not empty) passes through a pop state, because the
// ring memory has registered read data and the held slot is loaded from
// its registered output. One item is in flight at a time. The result sits in
// an output register; in_tready stays low while that register is full and
// not being taken. No clearing pass after reset: ring entries are only read
// after being written.
// ----------------------------------------------------------------------------
module input_event_queue_device
  import iqd_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] offset, [23:8] key_code, [39:24] modifiers, [40] pressed,
  // [48:41] text_char, [64:49] pointer_x, [80:65] pointer_y,
  // [88:81] button, [104:89] scroll_amount, [111:105] zero
  input  logic [111:0] in_tdata,
  // [2:0] mode
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] read_data
  output logic [31:0]  out_tdata
);

  localparam int unsigned AW = $clog2(RING_DEPTH);

  logic          ring_we, ring_re;
  logic [AW-1:0] ring_waddr, ring_raddr;
  event_t        ring_wdata, ring_rdata;

  iqd_ctrl #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .mode          (in_tuser),
    .offset        (in_tdata[7:0]),
    .key_code      (in_tdata[23:8]),
    .modifiers     (in_tdata[39:24]),
    .pressed       (in_tdata[40]),
    .text_char     (in_tdata[48:41]),
    .pointer_x     (in_tdata[64:49]),
    .pointer_y     (in_tdata[80:65]),
    .button        (in_tdata[88:81]),
    .scroll_amount (in_tdata[104:89]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .read_data     (out_tdata),
    .ring_we       (ring_we),
    .ring_waddr    (ring_waddr),
    .ring_wdata    (ring_wdata),
    .ring_re       (ring_re),
    .ring_raddr    (ring_raddr),
    .ring_rdata    (ring_rdata)
  );

  iqd_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_en   (ring_re),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

endmodule

FILE: src/iqd_ring.sv
// ----------------------------------------------------------------------------
// iqd_ring
// Event ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iqd_ring
  import iqd_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  event_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output event_t        rd_data
);

  event_t mem [DEPTH];
  event_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/iqd_ctrl.sv
// ----------------------------------------------------------------------------
// iqd_ctrl
// Sequencer: ring pointers, held event, pointer registers, result register.
// ----------------------------------------------------------------------------
module iqd_ctrl
  import iqd_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  // item in
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    mode,
  input  logic [7:0]    offset,
  input  logic [15:0]   key_code,
  input  logic [15:0]   modifiers,
  input  logic          pressed,
  input  logic [7:0]    text_char,
  input  logic [15:0]   pointer_x,
  input  logic [15:0]   pointer_y,
  input  logic [7:0]    button,
  input  logic [15:0]   scroll_amount,
  // result out
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   read_data,
  // ring ports
  output logic          ring_we,
  output logic [AW-1:0] ring_waddr,
  output event_t        ring_wdata,
  output logic          ring_re,
  output logic [AW-1:0] ring_raddr,
  input  event_t        ring_rdata
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  event_t        held_r, held_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [15:0]   px_r, px_nxt, py_r, py_nxt;
  logic [7:0]    op_off_r, op_off_nxt;
  logic          op_rd_r, op_rd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;

  logic          accept, empty, full, is_read, is_ack, pop_go;
  logic [AW-1:0] wp_inc, rp_inc;

  assign wp_inc = (wp_r == LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == LAST) ? '0 : rp_r + 1'b1;
  assign empty  = (wp_r == rp_r);
  assign full   = (wp_inc == rp_r);

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_read  = (mode == MODE_READ);
  assign is_ack   = (mode == MODE_WRITE) && (offset == REG_ACK_A || offset == REG_ACK_B);
  assign pop_go   = accept && !empty && ((is_read && !held_valid_r) || is_ack);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pop_go) state_nxt = ST_POP;
      ST_POP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    op_off_nxt     = op_off_r;
    op_rd_nxt      = op_rd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ring_we        = 1'b0;
    ring_wdata     = '0;
    ring_re        = pop_go;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_off_nxt = offset;
          op_rd_nxt  = is_read;
          if (pop_go) begin
            rp_nxt = rp_inc;
          end
          case (mode)
            MODE_READ: begin
              if (held_valid_r || empty) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = read_value(held_r, held_valid_r, offset, px_r, py_r);
              end
            end
            MODE_WRITE: begin
              if (is_ack) held_valid_nxt = 1'b0;
            end
            MODE_KEY: begin
              ring_we    = 1'b1;
              ring_wdata = {pressed, modifiers, key_code, TYPE_KEY};
            end
            MODE_TEXT: begin
              ring_we    = 1'b1;
              ring_wdata = {25'd0, text_char, TYPE_TEXT};
            end
            MODE_MOVE: begin
              ring_we    = 1'b1;
              ring_wdata = {31'd0, MSTATE_MOVE, TYPE_MOUSE};
              px_nxt     = pointer_x;
              py_nxt     = pointer_y;
            end
            MODE_BUTTON: begin
              ring_we    = 1'b1;
              ring_wdata = {23'd0, button, (pressed ? MSTATE_DOWN : MSTATE_UP), TYPE_MOUSE};
              px_nxt     = pointer_x;
              py_nxt     = pointer_y;
            end
            MODE_SCROLL: begin
              ring_we    = 1'b1;
              ring_wdata = {17'd0, scroll_amount, TYPE_SCROLL};
            end
            default: ;
          endcase
          // drop on full
          if (full) ring_we = 1'b0;
          if (ring_we) wp_nxt = wp_inc;
        end
      end
      ST_POP: begin
        held_nxt       = ring_rdata;
        held_valid_nxt = 1'b1;
        if (op_rd_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = read_value(ring_rdata, 1'b1, op_off_r, px_r, py_r);
        end
      end
      default: ;
    endcase
  end

  assign ring_waddr = wp_r;
  assign ring_raddr = rp_r;
  assign out_valid  = out_valid_r;
  assign read_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      rp_r         <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
      px_r         <= '0;
      py_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      px_r         <= px_nxt;
      py_r         <= py_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_off_r   <= op_off_nxt;
    op_rd_r    <= op_rd_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/iqd_checker.sv
// ----------------------------------------------------------------------------
// iqd_assertions
// Port-level checks of the input event queue device, bound to the top level.
// ----------------------------------------------------------------------------
module iqd_assertions
  import iqd_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [2:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  logic rd_acc;
  assign rd_acc = in_tvalid && in_tready && (in_tuser == MODE_READ);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a result only ever follows an accepted read, directly or after a ring pop
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rd_acc) || $past(rd_acc, 2))
    else $error("result without a read");

  // no new item while a result is stuck in the output register
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted while result stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind input_event_queue_device iqd_assertions u_iqd_assertions (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/iqd_checker.sv
// ----------------------------------------------------------------------------
// iqd_checker
// Watches both streams of the input event queue device, predicts every read
// item from a private copy of the ring and pointer state, and checks it.
// ----------------------------------------------------------------------------
module iqd_checker
  import iqd_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  output int unsigned  fail_count,
  output int unsigned  outstanding,
  output int unsigned  read_count,
  output int unsigned  event_count,
  output int unsigned  drop_count,
  output int unsigned  ack_count
);

  // predicted device state
  event_t      ring_mem [RING_DEPTH];
  int unsigned wr_slot;
  int unsigned rd_slot;
  event_t      held_word;
  logic        held_ok;
  logic [15:0] ptr_x;
  logic [15:0] ptr_y;

  logic [31:0] read_data_q [$];
  logic [31:0] want;

  function automatic int unsigned next_slot(input int unsigned i);
    return (i + 1 == RING_DEPTH) ? 0 : i + 1;
  endfunction

  task automatic queue_event(input event_t ev);
    event_count++;
    if (next_slot(wr_slot) == rd_slot) begin
      drop_count++;
    end else begin
      ring_mem[wr_slot] = ev;
      wr_slot = next_slot(wr_slot);
    end
  endtask

  task automatic take_next_event();
    if (wr_slot == rd_slot) begin
      held_ok = 1'b0;
    end else begin
      held_word = ring_mem[rd_slot];
      rd_slot   = next_slot(rd_slot);
      held_ok   = 1'b1;
    end
  endtask

  // register view of the held event and the pointer
  function automatic logic [31:0] register_value(input logic [7:0] off);
    logic [1:0]  kind;
    logic [32:0] body;
    kind = held_word[1:0];
    body = held_word[34:2];
    if (off == REG_PTR_X) return {16'd0, ptr_x};
    if (off == REG_PTR_Y) return {16'd0, ptr_y};
    if (!held_ok) return '0;
    case (off)
      REG_STATUS: begin
        if (kind == TYPE_KEY) return STAT_KEY;
        if (kind == TYPE_MOUSE) return STAT_MOUSE;
        if (kind == TYPE_TEXT) return STAT_TEXT;
        return STAT_SCROLL;
      end
      REG_KEY_CODE:  return (kind == TYPE_KEY) ? {16'd0, body[15:0]} : '0;
      REG_MODIFIERS: return (kind == TYPE_KEY) ? {16'd0, body[31:16]} : '0;
      REG_STATE_A, REG_STATE_B: begin
        if (kind == TYPE_KEY) return {31'd0, body[32]};
        if (kind == TYPE_MOUSE) return {30'd0, body[1:0]};
        return '0;
      end
      REG_TEXT:   return (kind == TYPE_TEXT) ? {24'd0, body[7:0]} : '0;
      REG_BUTTON: return (kind == TYPE_MOUSE) ? {24'd0, body[9:2]} : '0;
      REG_SCROLL: return (kind == TYPE_SCROLL) ? {{16{body[15]}}, body[15:0]} : '0;
      default:    return '0;
    endcase
  endfunction

  task automatic apply_item(input logic [2:0] mode, input logic [111:0] d);
    logic [7:0]  off;
    logic [15:0] code;
    logic [15:0] mods;
    logic        down;
    logic [7:0]  ch;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  btn;
    logic [15:0] scr;
    off  = d[7:0];
    code = d[23:8];
    mods = d[39:24];
    down = d[40];
    ch   = d[48:41];
    px   = d[64:49];
    py   = d[80:65];
    btn  = d[88:81];
    scr  = d[104:89];
    case (mode)
      MODE_READ: begin
        if (!held_ok) take_next_event();
        read_data_q.push_back(register_value(off));
        read_count++;
      end
      MODE_WRITE: begin
        if (off == REG_ACK_A || off == REG_ACK_B) begin
          held_ok = 1'b0;
          take_next_event();
          ack_count++;
        end
      end
      MODE_KEY:  queue_event({down, mods, code, TYPE_KEY});
      MODE_TEXT: queue_event({25'd0, ch, TYPE_TEXT});
      MODE_MOVE: begin
        ptr_x = px;
        ptr_y = py;
        queue_event({31'd0, MSTATE_MOVE, TYPE_MOUSE});
      end
      MODE_BUTTON: begin
        ptr_x = px;
        ptr_y = py;
        queue_event({23'd0, btn, down ? MSTATE_DOWN : MSTATE_UP, TYPE_MOUSE});
      end
      MODE_SCROLL: queue_event({17'd0, scr, TYPE_SCROLL});
      default: ;
    endcase
  endtask

  task automatic report_bad_read(input logic [31:0] exp_v, input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: read_data mismatch: expected %h, got %h", $realtime, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wr_slot     = 0;
      rd_slot     = 0;
      held_word   = '0;
      held_ok     = 1'b0;
      ptr_x       = '0;
      ptr_y       = '0;
      fail_count  = 0;
      read_count  = 0;
      event_count = 0;
      drop_count  = 0;
      ack_count   = 0;
      read_data_q.delete();
    end else begin
      if (in_tvalid && in_tready) apply_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (read_data_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: read item %h with no read pending", $realtime, out_tdata);
        end else begin
          want = read_data_q.pop_front();
          if (out_tdata !== want) report_bad_read(want, out_tdata);
        end
      end
    end
    outstanding = read_data_q.size();
  end

endmodule

FILE: tb/sv/input_event_queue_device_test.sv
// ----------------------------------------------------------------------------
// input_event_queue_device_test
// Stimulus and verdict for the input event queue device.
// ----------------------------------------------------------------------------
// A short directed pass touches all registers but button and scroll, every
// event kind with its extreme field values, the odd offsets and the unused
// mode. The random pass mixes event bursts read back and acknowledged, ring
// fills past capacity followed by a full drain, and noise items. The sender
// idles in random bursts; the receiver stalls on its own pattern, including
// two long hold-offs that back the block up. iqd_checker does all prediction.
// ----------------------------------------------------------------------------
module input_event_queue_device_test
  import iqd_pkg::*;
();

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned RESET_CYC   = 12;
  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned DRAIN_CYC   = 20;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned HOLD_A      = 1200;
  localparam int unsigned HOLD_B      = 2200;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;

  // in_tdata fields, top member in the highest bits
  typedef struct packed {
    logic [15:0] scroll_amount;
    logic [7:0]  button;
    logic [15:0] pointer_y;
    logic [15:0] pointer_x;
    logic [7:0]  text_char;
    logic        pressed;
    logic [15:0] modifiers;
    logic [15:0] key_code;
    logic [7:0]  offset;
  } host_fields_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // [7:0] offset, [23:8] key_code, [39:24] modifiers, [40] pressed,
  // [48:41] text_char, [64:49] pointer_x, [80:65] pointer_y,
  // [88:81] button, [104:89] scroll_amount, [111:105] zero
  logic [111:0] in_tdata = '0;
  // [2:0] mode
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] read_data
  logic [31:0]  out_tdata;

  int unsigned fail_count, outstanding;
  int unsigned read_count, event_count, drop_count, ack_count;

  int unsigned burst_left = 0;    // items left in the current sender burst
  int unsigned useful_items = 0;  // items the block acts on

  input_event_queue_device DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  iqd_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .read_count (read_count),
    .event_count(event_count),
    .drop_count (drop_count),
    .ack_count  (ack_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // single reset pulse, released on a falling edge
  initial begin
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * 400000);
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: phases of steady, random, periodic and sparse ready. Two long
  // hold-offs let reads pile up so the block has to stall its input.
  initial begin
    int unsigned rx_cycles;
    int unsigned phase_len;
    int unsigned style;
    int unsigned i;
    rx_cycles = 0;
    wait (rst_n);
    forever begin
      style     = $urandom_range(0, 3);
      phase_len = $urandom_range(50, 250);
      for (i = 0; i < phase_len; i++) begin
        @(negedge clk);
        rx_cycles++;
        if (rx_cycles == HOLD_A || rx_cycles == HOLD_B) begin
          out_tready <= 1'b0;
          repeat (HOLD_LEN) @(negedge clk);
          rx_cycles += HOLD_LEN;
        end
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (i % 5) < 3;
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic host_fields_t random_fields();
    logic [127:0] r;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    return r[104:0];
  endfunction

  // mostly mapped registers, sometimes any byte offset
  function automatic logic [7:0] pick_offset();
    if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0:       return REG_STATUS;
      1:       return REG_KEY_CODE;
      2:       return REG_MODIFIERS;
      3:       return REG_STATE_A;
      4:       return REG_TEXT;
      5:       return REG_ACK_A;
      6:       return REG_PTR_X;
      7:       return REG_PTR_Y;
      8:       return REG_BUTTON;
      9:       return REG_STATE_B;
      10:      return REG_SCROLL;
      default: return REG_ACK_B;
    endcase
  endfunction

  // one item with burst/gap idling in front; returns after the handshake
  task automatic send_item(input logic [2:0] mode, input host_fields_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, f};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    if (!(mode == MODE_UNUSED ||
          (mode == MODE_WRITE && f.offset != REG_ACK_A && f.offset != REG_ACK_B)))
      useful_items++;
  endtask

  task automatic send_read(input logic [7:0] off);
    host_fields_t f;
    f = random_fields();
    f.offset = off;
    send_item(MODE_READ, f);
  endtask

  task automatic send_write(input logic [7:0] off);
    host_fields_t f;
    f = random_fields();
    f.offset = off;
    send_item(MODE_WRITE, f);
  endtask

  task automatic send_ack();
    send_write($urandom_range(0, 1) ? REG_ACK_A : REG_ACK_B);
  endtask

  task automatic send_random_event();
    send_item(3'($urandom_range(MODE_KEY, MODE_SCROLL)), random_fields());
  endtask

  // push past capacity, then read and acknowledge everything back out
  task automatic fill_and_drain();
    repeat ($urandom_range(RING_DEPTH_DEF, RING_DEPTH_DEF + 12)) send_random_event();
    repeat (RING_DEPTH_DEF + 2) begin
      repeat ($urandom_range(0, 2)) send_read(pick_offset());
      send_ack();
    end
  endtask

  initial begin
    host_fields_t f;
    int unsigned  fills_done;
    int unsigned  pick;
    int unsigned  n_ev;
    fills_done = 0;
    wait (rst_n);

    // ---- directed ----
    send_read(REG_STATUS);          // nothing held: zero
    send_read(REG_PTR_X);           // pointer still at reset
    send_write(REG_ACK_A);          // acknowledge with nothing held
    f = random_fields();
    f.key_code = 16'hFFFF; f.modifiers = 16'h0000; f.pressed = 1'b1;
    send_item(MODE_KEY, f);
    f = random_fields();
    f.key_code = 16'h0000; f.modifiers = 16'hFFFF; f.pressed = 1'b0;
    send_item(MODE_KEY, f);
    f = random_fields();
    f.text_char = 8'hFF;
    send_item(MODE_TEXT, f);
    f = random_fields();
    f.pointer_x = 16'hFFFF; f.pointer_y = 16'h0000;
    send_item(MODE_MOVE, f);
    f = random_fields();
    f.pointer_x = 16'h0000; f.pointer_y = 16'hFFFF; f.button = 8'hFF; f.pressed = 1'b0;
    send_item(MODE_BUTTON, f);
    f = random_fields();
    f.button = 8'h00; f.pressed = 1'b1;
    send_item(MODE_BUTTON, f);
    f = random_fields();
    f.scroll_amount = 16'h8000;     // most negative scroll
    send_item(MODE_SCROLL, f);
    f = random_fields();
    f.scroll_amount = 16'h7FFF;
    send_item(MODE_SCROLL, f);
    send_item(MODE_UNUSED, random_fields());
    send_read(REG_STATUS);          // pops the first key
    send_read(REG_KEY_CODE);
    send_read(REG_MODIFIERS);
    send_read(REG_STATE_B);
    send_read(REG_TEXT);            // field not valid for a key
    send_read(8'h05);               // unaligned
    send_read(REG_ACK_A);           // acknowledge offset reads as unmapped
    send_write(REG_TEXT);           // plain write, ignored
    send_write(REG_ACK_B);          // second key
    send_read(REG_STATE_A);
    send_ack();                     // text
    send_read(REG_TEXT);
    send_read(REG_PTR_Y);

    // ---- random ----
    while (useful_items < ITEM_TARGET) begin
      if (fills_done < 2 && useful_items >= 400 + 500 * fills_done) begin
        fill_and_drain();
        fills_done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // well-formed: a few events, each read back then acknowledged
          n_ev = $urandom_range(1, 4);
          repeat (n_ev) send_random_event();
          repeat (n_ev) begin
            repeat ($urandom_range(1, 4)) send_read(pick_offset());
            send_ack();
          end
        end else if (pick < 80) begin
          // noise: any mode, any offset
          repeat ($urandom_range(1, 6)) begin
            f = random_fields();
            if ($urandom_range(0, 1)) f.offset = pick_offset();
            send_item(3'($urandom_range(0, 7)), f);
          end
        end else begin
          // broken sequences: reads and acknowledges with little queued
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1)) send_read(pick_offset());
            else send_ack();
          end
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d bus reads, %0d host events (%0d dropped on a full ring),",
             read_count, event_count, drop_count);
    $display("%0d acknowledges, %0d ring fills and two long output hold-offs.",
             ack_count, fills_done);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
